// ----- src/fuzzy_match_best_word_assert.svh -----
// assertion macros shared by the fuzzy word matcher
// needs a clock and an active-low reset in scope of the user
`ifndef FUZZY_MATCH_BEST_WORD_ASSERT_SVH
`define FUZZY_MATCH_BEST_WORD_ASSERT_SVH

// same-cycle implication
`define FMBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FMBW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fmbw_pkg.sv -----
// shared types, constants and the per-byte scoring function
// of the fuzzy word matcher; no dependencies
package fmbw_pkg;

  localparam int QueryMax = 64;
  localparam int WordMax  = 64;
  localparam int WordsMax = 1024;

  localparam int QAddrW = $clog2(QueryMax);
  localparam int QLenW  = $clog2(QueryMax + 1);
  localparam int WLenW  = $clog2(WordMax + 1);
  localparam int IdxW   = $clog2(WordsMax);
  localparam int ScoreW = 11;
  localparam int PenW   = 5;

  localparam logic [7:0] CaseMask = 8'hDF;
  localparam logic [7:0] SepMax   = 8'd32;

  localparam int MatchFirst = 10;
  localparam int MatchRun   = 5;
  localparam int PenStep    = 3;
  localparam int PenFloor   = -9;
  localparam logic signed [ScoreW-1:0] ScoreFloor = ScoreW'(-1015);

  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  // per-request control from the input stage
  typedef struct packed {
    logic append;
    logic clear;
    logic word_byte;
    logic word_end;
    logic last_word;
  } ctrl_t;

  // state touched by scoring one byte
  typedef struct packed {
    logic [QLenW-1:0]         ptr;
    logic [7:0]               prev;
    logic                     consec;
    logic signed [ScoreW-1:0] score;
    logic signed [PenW-1:0]   pen;
  } score_st_t;

  function automatic score_st_t score_step(score_st_t st, logic [7:0] c, logic [7:0] nxt,
                                           logic [7:0] q, logic [QLenW-1:0] qlen);
    score_st_t                r;
    logic                     leading;
    logic                     sep;
    logic signed [ScoreW-1:0] gain;
    logic signed [PenW:0]     pen_m;
    r       = st;
    leading = c[6] & ~nxt[6];
    sep     = st.prev[7] | (st.prev <= SepMax);
    gain    = '0;
    pen_m   = (PenW+1)'(st.pen) - (PenW+1)'(PenStep);
    if (st.ptr < qlen) begin
      if ((c & CaseMask) == (q & CaseMask)) begin
        if (sep || leading) begin
          gain = ScoreW'(MatchFirst);
        end else if (st.consec) begin
          gain = ScoreW'(MatchRun);
        end
        r.consec = 1'b1;
        r.score  = st.score + gain;
        r.ptr    = st.ptr + QLenW'(1);
      end else begin
        r.consec = 1'b0;
        if (st.score > ScoreFloor) begin
          r.score = st.score - ScoreW'(1);
        end
        if (leading) begin
          if (pen_m < (PenW+1)'(PenFloor)) begin
            r.pen = PenW'(PenFloor);
          end else begin
            r.pen = pen_m[PenW-1:0];
          end
        end
      end
      r.prev = c;
    end
    return r;
  endfunction

endpackage

// ----- src/fmbw_qmem.sv -----
// query store: one write port, two registered read ports with write bypass
// depends on fmbw_pkg
module fmbw_qmem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fmbw_pkg::ctrl_t           ctrl_i,
  input  logic [7:0]                wdata_i,
  input  logic [fmbw_pkg::QLenW-1:0] rptr_i,
  output logic [7:0]                rd0_o,
  output logic [7:0]                rd1_o,
  output logic [fmbw_pkg::QLenW-1:0] qlen_o
);

  logic [7:0]                 mem [fmbw_pkg::QueryMax];
  logic [fmbw_pkg::QLenW-1:0] qlen_q, qlen_d;
  logic                       we;
  logic [fmbw_pkg::QAddrW-1:0] waddr, raddr0, raddr1;
  logic [7:0]                 rd0_q, rd1_q;

  assign we     = ctrl_i.append && (qlen_q < fmbw_pkg::QLenW'(fmbw_pkg::QueryMax));
  assign waddr  = qlen_q[fmbw_pkg::QAddrW-1:0];
  assign raddr0 = rptr_i[fmbw_pkg::QAddrW-1:0];
  assign raddr1 = raddr0 + fmbw_pkg::QAddrW'(1);

  always_comb begin
    qlen_d = qlen_q;
    if (ctrl_i.clear) begin
      qlen_d = '0;
    end else if (we) begin
      qlen_d = qlen_q + fmbw_pkg::QLenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= '0;
    end else begin
      qlen_q <= qlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata_i;
    end
  end

  // read with write-first bypass
  always_ff @(posedge clk_i) begin
    if (we && (waddr == raddr0)) begin
      rd0_q <= wdata_i;
    end else begin
      rd0_q <= mem[raddr0];
    end
    if (we && (waddr == raddr1)) begin
      rd1_q <= wdata_i;
    end else begin
      rd1_q <= mem[raddr1];
    end
  end

  assign rd0_o  = rd0_q;
  assign rd1_o  = rd1_q;
  assign qlen_o = qlen_q;

endmodule

// ----- src/fmbw_word.sv -----
// per-word scoring state: held-back byte, query pointer, score and penalty
// depends on fmbw_pkg
module fmbw_word (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fmbw_pkg::ctrl_t                  ctrl_i,
  input  logic [7:0]                       byte_i,
  input  logic [7:0]                       rd0_i,
  input  logic [7:0]                       rd1_i,
  input  logic [fmbw_pkg::QLenW-1:0]       qlen_i,
  output logic [fmbw_pkg::QLenW-1:0]       ptr_d_o,
  output logic signed [fmbw_pkg::ScoreW-1:0] total_o,
  output logic [fmbw_pkg::WLenW-1:0]       wlen_o
);

  fmbw_pkg::score_st_t        st_q, st_d, st1, st2;
  logic [7:0]                 pend_q, pend_d;
  logic                       pend_vld_q, pend_vld_d;
  logic [fmbw_pkg::WLenW-1:0] wlen_q, wlen_d, wlen_inc;
  logic [7:0]                 q_b;

  // held byte first, then the current byte if it closes the word
  always_comb begin
    st1 = st_q;
    if (pend_vld_q) begin
      st1 = fmbw_pkg::score_step(st_q, pend_q, byte_i, rd0_i, qlen_i);
    end
    q_b = (st1.ptr != st_q.ptr) ? rd1_i : rd0_i;
    st2 = fmbw_pkg::score_step(st1, byte_i, 8'd0, q_b, qlen_i);
  end

  assign wlen_inc = (wlen_q < fmbw_pkg::WLenW'(fmbw_pkg::WordMax)) ?
                    wlen_q + fmbw_pkg::WLenW'(1) : wlen_q;

  always_comb begin
    st_d       = st_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    wlen_d     = wlen_q;
    if (ctrl_i.clear || ctrl_i.word_end) begin
      st_d       = '0;
      pend_d     = '0;
      pend_vld_d = 1'b0;
      wlen_d     = '0;
    end else if (ctrl_i.word_byte) begin
      st_d       = st1;
      pend_d     = byte_i;
      pend_vld_d = 1'b1;
      wlen_d     = wlen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      wlen_q     <= '0;
    end else begin
      st_q       <= st_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      wlen_q     <= wlen_d;
    end
  end

  assign ptr_d_o = st_d.ptr;
  assign total_o = st2.score + fmbw_pkg::ScoreW'(st2.pen);
  assign wlen_o  = wlen_inc;

endmodule

// ----- src/fmbw_best.sv -----
// best-word tracker and word index counter
// depends on fmbw_pkg
module fmbw_best (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fmbw_pkg::ctrl_t                    ctrl_i,
  input  logic signed [fmbw_pkg::ScoreW-1:0] total_i,
  input  logic [fmbw_pkg::WLenW-1:0]         wlen_i,
  output logic [fmbw_pkg::IdxW-1:0]          word_index_o,
  output logic [fmbw_pkg::IdxW-1:0]          best_index_o,
  output logic                               best_found_o
);

  logic [fmbw_pkg::IdxW-1:0]          idx_q, idx_d;
  logic signed [fmbw_pkg::ScoreW-1:0] bscore_q, bscore_d, bscore_upd;
  logic [fmbw_pkg::IdxW-1:0]          bword_q, bword_d, bword_upd;
  logic [fmbw_pkg::WLenW-1:0]         blen_q, blen_d, blen_upd;
  logic                               bvld_q, bvld_d, bvld_upd;
  logic                               keep;

  // ties keep a strictly shorter valid best
  always_comb begin
    bscore_upd = bscore_q;
    bword_upd  = bword_q;
    blen_upd   = blen_q;
    bvld_upd   = bvld_q;
    keep       = (total_i == bscore_q) && bvld_q && (blen_q < wlen_i);
    if (total_i >= bscore_q) begin
      if (!keep) begin
        bword_upd = idx_q;
        blen_upd  = wlen_i;
      end
      bscore_upd = total_i;
      bvld_upd   = 1'b1;
    end
  end

  always_comb begin
    idx_d    = idx_q;
    bscore_d = bscore_q;
    bword_d  = bword_q;
    blen_d   = blen_q;
    bvld_d   = bvld_q;
    if (ctrl_i.clear || (ctrl_i.word_end && ctrl_i.last_word)) begin
      idx_d    = '0;
      bscore_d = '0;
      bword_d  = '0;
      blen_d   = '0;
      bvld_d   = 1'b0;
    end else if (ctrl_i.word_end) begin
      if (idx_q < fmbw_pkg::IdxW'(fmbw_pkg::WordsMax - 1)) begin
        idx_d = idx_q + fmbw_pkg::IdxW'(1);
      end
      bscore_d = bscore_upd;
      bword_d  = bword_upd;
      blen_d   = blen_upd;
      bvld_d   = bvld_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      bscore_q <= '0;
      bword_q  <= '0;
      blen_q   <= '0;
      bvld_q   <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      bscore_q <= bscore_d;
      bword_q  <= bword_d;
      blen_q   <= blen_d;
      bvld_q   <= bvld_d;
    end
  end

  assign word_index_o = idx_q;
  assign best_index_o = bword_upd;
  assign best_found_o = bvld_upd;

endmodule

// ----- src/fuzzy_match_best_word.sv -----
// fuzzy word matcher top level: a word-end request loads the result register
// throughput one request per cycle while the result side takes results
// one input register, one scoring pass, one result register
// async active-low reset clears all control and search state and empties the query
// query bytes stored before reset are lost; no clearing pass is needed
// depends on fmbw_pkg, fmbw_qmem, fmbw_word, fmbw_best and the assertion header
`include "fuzzy_match_best_word_assert.svh"

module fuzzy_match_best_word (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] action, [2] last_word
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] word_index, [20:10] word_score,
                                      // [30:21] best_index, [31] best_found
  output logic        m_axis_tlast    // search_done
);

  // input register
  logic       in_vld_q, in_vld_d;
  logic [1:0] in_act_q;
  logic [7:0] in_byte_q;
  logic       in_lc_q, in_lw_q;
  logic       advance;

  // result register
  logic                               out_vld_q, out_vld_d;
  logic [fmbw_pkg::IdxW-1:0]          out_widx_q;
  logic signed [fmbw_pkg::ScoreW-1:0] out_score_q;
  logic [fmbw_pkg::IdxW-1:0]          out_bidx_q;
  logic                               out_bfound_q;
  logic                               out_done_q;

  fmbw_pkg::ctrl_t                    ctrl;
  logic [7:0]                         rd0, rd1;
  logic [fmbw_pkg::QLenW-1:0]         qlen, ptr_d;
  logic signed [fmbw_pkg::ScoreW-1:0] total;
  logic [fmbw_pkg::WLenW-1:0]         wlen;
  logic [fmbw_pkg::IdxW-1:0]          word_index, best_index;
  logic                               best_found;

  // the held request moves on when the result slot is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q  <= s_axis_tuser[1:0];
      in_byte_q <= s_axis_tdata;
      in_lc_q   <= s_axis_tlast;
      in_lw_q   <= s_axis_tuser[2];
    end
  end

  // decode the held request; the unused action code does nothing
  always_comb begin
    ctrl           = '0;
    ctrl.last_word = in_lw_q;
    if (advance) begin
      unique case (in_act_q)
        fmbw_pkg::ACT_QUERY: ctrl.append = 1'b1;
        fmbw_pkg::ACT_CLEAR: ctrl.clear = 1'b1;
        fmbw_pkg::ACT_WORD: begin
          ctrl.word_byte = 1'b1;
          ctrl.word_end  = in_lc_q;
        end
        default: ctrl = '0;
      endcase
    end
  end

  // query store, read at the pointer the word logic will hold next cycle
  fmbw_qmem u_qmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .wdata_i (in_byte_q),
    .rptr_i  (ptr_d),
    .rd0_o   (rd0),
    .rd1_o   (rd1),
    .qlen_o  (qlen)
  );

  // word scoring: each byte is held one request so its successor is known
  fmbw_word u_word (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .byte_i  (in_byte_q),
    .rd0_i   (rd0),
    .rd1_i   (rd1),
    .qlen_i  (qlen),
    .ptr_d_o (ptr_d),
    .total_o (total),
    .wlen_o  (wlen)
  );

  // best word across the list
  fmbw_best u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .total_i      (total),
    .wlen_i       (wlen),
    .word_index_o (word_index),
    .best_index_o (best_index),
    .best_found_o (best_found)
  );

  // result register, loaded only at a word end
  always_comb begin
    out_vld_d = out_vld_q;
    if (ctrl.word_end) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.word_end) begin
      out_widx_q   <= word_index;
      out_score_q  <= total;
      out_bidx_q   <= best_index;
      out_bfound_q <= best_found;
      out_done_q   <= in_lw_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_bfound_q, out_bidx_q, out_score_q, out_widx_q};
  assign m_axis_tlast  = out_done_q;

  `FMBW_ASSERT_IMP(a_qlen_cap, clk_i, rst_ni, 1'b1,
                   qlen <= fmbw_pkg::QLenW'(fmbw_pkg::QueryMax), "query length over capacity")
  `FMBW_ASSERT_NXT(a_word_end_result, clk_i, rst_ni, ctrl.word_end, m_axis_tvalid,
                   "word end without a result")
  `FMBW_ASSERT_IMP(a_nonneg_found, clk_i, rst_ni, out_vld_q && !out_score_q[fmbw_pkg::ScoreW-1],
                   out_bfound_q, "nonnegative score but no best word")

endmodule

// ----- sim/tb_fuzzy_match_best_word.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the fuzzy word matcher: a scoreboard class predicts
// every word result from the accepted requests; depends on fmbw_pkg and the block

module tb_fuzzy_match_best_word;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused action code, block ignores it
  localparam int SCORE_MIN    = -1015;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    logic [9:0]        word_idx;
    logic signed [10:0] score;
    logic [9:0]        best_idx;
    logic              found;
    logic              done;
  } word_result_t;

  // running copy of the matcher state and the word results still owed by the block
  class match_score_book;
    logic [7:0]   qmem [fmbw_pkg::QueryMax];
    int           qlen;
    int           qptr;
    logic [7:0]   held;
    bit           held_v;
    logic [7:0]   prev;
    bit           consec;
    int           score;
    int           pen;
    int           wlen;
    int           idx;
    int           best_sc;
    int           best_idx;
    int           best_len;
    bit           best_v;
    word_result_t due_results[$];
    int           errors;
    int           words;
    int           lists;

    function new();
      qlen   = 0;
      errors = 0;
      words  = 0;
      lists  = 0;
      clear_search();
    endfunction

    function void clear_word();
      qptr   = 0;
      held   = 8'h00;
      held_v = 1'b0;
      prev   = 8'h00;
      consec = 1'b0;
      score  = 0;
      pen    = 0;
      wlen   = 0;
    endfunction

    function void clear_search();
      clear_word();
      idx      = 0;
      best_sc  = 0;
      best_idx = 0;
      best_len = 0;
      best_v   = 1'b0;
    endfunction

    // score one character against the query position; nxt decides leading letters
    function void score_char(logic [7:0] c, logic [7:0] nxt);
      bit lead;
      bit sep;
      if (qptr >= qlen) return;
      lead = c[6] & ~nxt[6];
      if ((c & fmbw_pkg::CaseMask) == (qmem[qptr] & fmbw_pkg::CaseMask)) begin
        sep = (prev <= fmbw_pkg::SepMax) || prev[7];
        if (sep || lead) begin
          score += fmbw_pkg::MatchFirst;
        end else if (consec) begin
          score += fmbw_pkg::MatchRun;
        end
        consec = 1'b1;
        qptr++;
      end else begin
        consec = 1'b0;
        if (score > SCORE_MIN) score--;
        if (lead) begin
          pen -= fmbw_pkg::PenStep;
          if (pen < fmbw_pkg::PenFloor) pen = fmbw_pkg::PenFloor;
        end
      end
      prev = c;
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] d, logic lc, logic lw);
      word_result_t r;
      int           total;
      case (act)
        fmbw_pkg::ACT_QUERY: begin
          if (qlen < fmbw_pkg::QueryMax) begin
            qmem[qlen] = d;
            qlen++;
          end
        end
        fmbw_pkg::ACT_CLEAR: begin
          qlen = 0;
          clear_search();
        end
        fmbw_pkg::ACT_WORD: begin
          // each byte is scored one request late, once its successor is known
          if (held_v) score_char(held, d);
          if (wlen < fmbw_pkg::WordMax) wlen++;
          if (!lc) begin
            held   = d;
            held_v = 1'b1;
          end else begin
            score_char(d, 8'h00);
            total = score + pen;
            if (total >= best_sc) begin
              // ties keep the older word only when it is strictly shorter
              if (!(total == best_sc && best_v && best_len < wlen)) begin
                best_idx = idx;
                best_len = wlen;
              end
              best_sc = total;
              best_v  = 1'b1;
            end
            r.word_idx = idx[9:0];
            r.score    = total[10:0];
            r.best_idx = best_idx[9:0];
            r.found    = best_v;
            r.done     = lw;
            due_results.push_back(r);
            if (lw) begin
              clear_search();
            end else begin
              clear_word();
              if (idx < fmbw_pkg::WordsMax - 1) idx++;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string field, int got, int want);
      errors++;
      $display("word result %0d: %s is %0d, expected %0d", words, field, got, want);
    endtask

    task check_result(logic [31:0] d, logic done);
      word_result_t w;
      if (due_results.size() == 0) begin
        report("result with no word pending, word_index", d[9:0], 0);
        return;
      end
      w = due_results.pop_front();
      words++;
      if (d[9:0] != w.word_idx) report("word_index", d[9:0], w.word_idx);
      if (d[20:10] != w.score) report("word_score", $signed(d[20:10]), w.score);
      if (d[30:21] != w.best_idx) report("best_index", d[30:21], w.best_idx);
      if (d[31] != w.found) report("best_found", d[31], w.found);
      if (done != w.done) report("search_done", done, w.done);
      if (done) lists++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  match_score_book book;
  logic [7:0]      query_text[$];  // query as the stimulus believes it, for building matches
  int              sent_items  = 0;
  int              idle_cycles = 0;
  bit              no_idle     = 1'b0;

  fuzzy_match_best_word uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic send_req(logic [1:0] act, logic [7:0] d, logic lc, logic lw);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= {lw, act};
    s_axis_tlast  <= lc;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act != ACT_SPARE) sent_items++;
  endtask

  task automatic append_query(logic [7:0] d);
    send_req(fmbw_pkg::ACT_QUERY, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (query_text.size() < fmbw_pkg::QueryMax) query_text.push_back(d);
  endtask

  task automatic clear_query();
    send_req(fmbw_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    query_text.delete();
  endtask

  // word that follows the query in order with case flips, separators and noise mixed in
  task automatic send_word(int len, bit lw, bit noisy);
    int         p;
    int         r;
    logic [7:0] c;
    p = 0;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          append_query(8'($urandom_range(8'h41, 8'h7A)));
        end else if (r == 3) begin
          clear_query();
        end else if (r == 4) begin
          send_req(ACT_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
      end
      r = $urandom_range(0, 9);
      if (r < 5 && p < query_text.size()) begin
        c = query_text[p] ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        p++;
      end else if (r < 7) begin
        case ($urandom_range(0, 3))
          0:       c = 8'h20;
          1:       c = 8'h00;
          2:       c = 8'h80 | 8'($urandom_range(0, 127));
          default: c = 8'($urandom_range(0, 32));
        endcase
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      send_req(fmbw_pkg::ACT_WORD, c, i == len - 1,
               (i == len - 1) ? lw : 1'($urandom_range(0, 1)));
    end
  endtask

  // monitor: results are checked before requests are noted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) begin
        book.note_request(s_axis_tuser[1:0], s_axis_tdata, s_axis_tlast, s_axis_tuser[2]);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls between results
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("fuzzy_match_best_word test failed");
    $finish;
  end

  initial begin
    logic [7:0] caps [7];
    int         base;
    int         r;
    int         n;
    caps = '{8'h58, 8'h20, 8'h59, 8'h20, 8'h5A, 8'h20, 8'h57};
    book = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 3'b000;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // word with an empty query scores zero and still becomes the best
    send_req(fmbw_pkg::ACT_WORD, 8'h41, 1'b1, 1'b0);
    send_req(ACT_SPARE, 8'hFF, 1'b1, 1'b1);
    append_query(8'h46);
    append_query(8'h62);
    // zero byte, case-folded run, leading letter at the end
    send_req(fmbw_pkg::ACT_WORD, 8'h00, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h66, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h42, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h7A, 1'b1, 1'b0);
    // a high byte, then a space that counts as a separator
    send_req(fmbw_pkg::ACT_WORD, 8'hC6, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h20, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h66, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h62, 1'b1, 1'b0);
    // shorter word with a higher score, closes the list
    send_req(fmbw_pkg::ACT_WORD, 8'h66, 1'b0, 1'b1);
    send_req(fmbw_pkg::ACT_WORD, 8'h62, 1'b1, 1'b1);
    // leading-letter misses push the penalty onto its clamp, nothing found
    foreach (caps[i]) send_req(fmbw_pkg::ACT_WORD, caps[i], i == 6, 1'b1);
    clear_query();
    send_req(fmbw_pkg::ACT_WORD, 8'hFF, 1'b0, 1'b0);
    send_req(fmbw_pkg::ACT_WORD, 8'h80, 1'b1, 1'b1);

    // long miss word: length saturates at the word limit
    clear_query();
    append_query(8'h71);
    for (int i = 0; i < 70; i++) send_req(fmbw_pkg::ACT_WORD, 8'h01, i == 69, 1'b1);

    base = sent_items;
    while (sent_items - base < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        clear_query();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        for (int i = 0; i < n; i++) begin
          append_query(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(8'h41, 8'h7A)));
        end
      end else if (r < 13) begin
        send_req(ACT_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      end else if (r < 16) begin
        append_query(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          send_word(($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10),
                    (k == n - 1) && ($urandom_range(0, 4) != 0), 1'b1);
        end
      end
    end

    no_idle = 1'b1;
    s_axis_tvalid <= 1'b0;
    while (book.due_results.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    $display("%0d requests, %0d word results checked over %0d finished searches",
             sent_items, book.words, book.lists);
    $display("ties, separators, penalty clamp and word length saturation included");
    if (book.errors == 0) begin
      $display("fuzzy_match_best_word test passed");
    end else begin
      $display("fuzzy_match_best_word test failed");
    end
    $finish;
  end

endmodule
